@@ sv/arp_cache_resolver_responder_top_macros.svh @@
// Assertion macros for the ARP cache resolver and responder.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef ARP_CACHE_RESOLVER_RESPONDER_TOP_MACROS_SVH
`define ARP_CACHE_RESOLVER_RESPONDER_TOP_MACROS_SVH

// Condition a implies condition c in the same cycle.
`define ARPCR_ASSERT_NOW(label, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error(msg);

// Condition a implies condition c in the next cycle.
`define ARPCR_ASSERT_NEXT(label, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error(msg);

`endif

@@ sv/arpcr_pkg.sv @@
// Shared types and constants of the ARP cache resolver and responder.
// Used by arpcr_cell and arp_cache_resolver_responder_top; no dependencies.
`default_nettype none

package arpcr_pkg;

	localparam logic [1:0]  ARP_OP_REQUEST = 2'd1;
	localparam logic [1:0]  ARP_OP_REPLY   = 2'd2;
	localparam logic [15:0] RX_OP_REQUEST  = 16'h0001;
	localparam logic [47:0] MAC_BCAST      = 48'hFFFF_FFFF_FFFF;
	localparam logic [47:0] MAC_ZERO       = 48'h0;

	localparam logic        REG_OWN_IP  = 1'b0;
	localparam logic        REG_OWN_MAC = 1'b1;

	// Search token that walks the cell chain, one cell per cycle.
	typedef struct packed {
		logic        valid;
		logic [31:0] key;
		logic        found;
		logic [47:0] mac;
		logic        cmpl;
	} token_t;

	// Write command broadcast to all cells when an item commits.
	typedef struct packed {
		logic        upd;
		logic        app;
		logic [31:0] ip;
		logic [47:0] mac;
		logic        cmpl;
	} cmd_t;

endpackage

`default_nettype wire

@@ sv/arp_cache_resolver_responder_top.sv @@
// ARP cache resolver and responder: a chain of CACHE_ENTRIES cells holds the cache.
// An accepted item's search token passes through the cell registers into a finish register;
// the item then commits into the output register once that is free. A new item is taken only
// after the last one has committed: the token walks the cell chain, one cell per cycle.
// Reset: asynchronous, active low; clears the cache fill count, complete flags,
// configuration registers and control state. No clearing pass is needed.
`default_nettype none

module arp_cache_resolver_responder_top #(
	parameter int CACHE_ENTRIES = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	// Configuration port.
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [3:0]  paddr,
	input  wire  [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	// Input channel.
	input  wire         in_valid,
	output logic        in_stall,
	input  wire         op,
	input  wire  [31:0] query_ip,
	input  wire  [15:0] frame_opcode,
	input  wire  [47:0] frame_sender_mac,
	input  wire  [31:0] frame_sender_ip,
	input  wire  [31:0] frame_target_ip,
	// Output channel.
	output logic        out_valid,
	input  wire         out_stall,
	output logic [1:0]  out_opcode,
	output logic [47:0] eth_dst_mac,
	output logic [47:0] out_sender_mac,
	output logic [31:0] out_sender_ip,
	output logic [47:0] out_target_mac,
	output logic [31:0] out_target_ip,
	output logic        cache_hit,
	output logic        table_full
);
	import arpcr_pkg::*;

	localparam int N  = CACHE_ENTRIES;
	localparam int FW = $clog2(N + 1);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH} state_t;

	state_t      state_q;
	logic [31:0] own_ip_q;
	logic [47:0] own_mac_q;
	logic [FW-1:0] fill_q;

	// Fields of the item under way, held from acceptance to commit.
	logic        op_q;
	logic [15:0] fop_q;
	logic [47:0] smac_q;
	logic [31:0] sip_q;
	logic [31:0] tip_q;

	token_t      tok [0:N];
	token_t      fin_q;
	logic [N-1:0] hit_vec;
	cmd_t        cmd;

	logic        accept;
	logic        cfg_wr;
	logic        out_free;
	logic        commit;
	logic        room;

	// Result of the commit, loaded into the output register.
	logic        res_en;
	logic [1:0]  res_opcode;
	logic [47:0] res_dst;
	logic [47:0] res_tmac;
	logic [31:0] res_tip;
	logic        res_hit;
	logic        res_full;

	// The configuration registers sit at byte addresses 0 and 8; only the
	// address bit that selects between them is decoded.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		case (paddr[3])
			REG_OWN_IP:  prdata = {32'h0, own_ip_q};
			REG_OWN_MAC: prdata = {16'h0, own_mac_q};
			default:     prdata = 64'h0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q  <= 32'h0;
			own_mac_q <= 48'h0;
		end else if (cfg_wr) begin
			case (paddr[3])
				REG_OWN_IP:  own_ip_q  <= pwdata[31:0];
				REG_OWN_MAC: own_mac_q <= pwdata[47:0];
				default:     own_ip_q  <= own_ip_q;
			endcase
		end
	end

	// One item at a time: a new item is taken only while no search runs or waits to commit.
	// A finished result may still wait in the output register meanwhile.
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	// The search token enters the first cell in the cycle the item is taken.
	// A resolve item looks up the query IP, a frame its sender IP.
	always_comb begin
		tok[0].valid = accept;
		tok[0].key   = op ? frame_sender_ip : query_ip;
		tok[0].found = 1'b0;
		tok[0].mac   = MAC_ZERO;
		tok[0].cmpl  = 1'b0;
	end

	for (genvar g = 0; g < N; g++) begin : g_cell
		arpcr_cell #(
			.INDEX (g),
			.FW    (FW)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.fill   (fill_q),
			.tin    (tok[g]),
			.tout   (tok[g+1]),
			.cmd    (cmd),
			.hit    (hit_vec[g])
		);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op;
			fop_q  <= frame_opcode;
			smac_q <= frame_sender_mac;
			sip_q  <= frame_sender_ip;
			tip_q  <= frame_target_ip;
		end
		if (tok[N].valid) begin
			fin_q <= tok[N];
		end
	end

	// The item commits once the token has left the chain and the output
	// register is free or being emptied in this cycle.
	assign out_free = !out_valid || !out_stall;
	assign commit   = (state_q == ST_FINISH) && out_free;
	assign room     = fill_q < FW'(N);

	always_comb begin
		cmd        = '0;
		res_en     = 1'b0;
		res_opcode = ARP_OP_REQUEST;
		res_dst    = MAC_BCAST;
		res_tmac   = MAC_ZERO;
		res_tip    = sip_q;
		res_hit    = 1'b0;
		res_full   = 1'b0;
		if (!op_q) begin
			// Resolve: a complete entry gives a unicast request, anything
			// else a broadcast and, for an unknown IP, an incomplete entry if there is room.
			res_en  = 1'b1;
			res_tip = fin_q.key;
			res_hit = fin_q.found && fin_q.cmpl;
			if (res_hit) begin
				res_dst  = fin_q.mac;
				res_tmac = fin_q.mac;
			end
			if (!fin_q.found) begin
				if (room) begin
					cmd.app = 1'b1;
				end else begin
					res_full = 1'b1;
				end
			end
			cmd.ip   = fin_q.key;
			cmd.mac  = MAC_ZERO;
			cmd.cmpl = 1'b0;
		end else if (tip_q == own_ip_q) begin
			// A frame for us completes the sender's entry; a request also
			// adds the sender when it is unknown and there is room, and is answered.
			cmd.upd  = fin_q.found;
			cmd.ip   = sip_q;
			cmd.mac  = smac_q;
			cmd.cmpl = 1'b1;
			if (fop_q == RX_OP_REQUEST) begin
				res_en     = 1'b1;
				res_opcode = ARP_OP_REPLY;
				res_dst    = smac_q;
				res_tmac   = smac_q;
				if (!fin_q.found) begin
					if (room) begin
						cmd.app = 1'b1;
					end else begin
						res_full = 1'b1;
					end
				end
			end
		end
		if (!commit) begin
			cmd.upd = 1'b0;
			cmd.app = 1'b0;
			res_en  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			fill_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (tok[N].valid) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cmd.app) begin
				fill_q <= fill_q + 1'b1;
			end
			if (res_en) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// The sender fields always carry our own addresses at commit time.
	always_ff @(posedge clk) begin
		if (res_en) begin
			out_opcode     <= res_opcode;
			eth_dst_mac    <= res_dst;
			out_sender_mac <= own_mac_q;
			out_sender_ip  <= own_ip_q;
			out_target_mac <= res_tmac;
			out_target_ip  <= res_tip;
			cache_hit      <= res_hit;
			table_full     <= res_full;
		end
	end

`include "arp_cache_resolver_responder_top_macros.svh"

	`ARPCR_ASSERT_NEXT(a_accept_starts_scan, accept, state_q == ST_SCAN, "accept without scan")
	`ARPCR_ASSERT_NOW(a_token_exit_in_scan, tok[N].valid, state_q == ST_SCAN, "stray token")
	`ARPCR_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= FW'(N), "fill count beyond cache size")
	`ARPCR_ASSERT_NOW(a_single_hit, state_q == ST_FINISH, $onehot0(hit_vec), "several cells hit")
	`ARPCR_ASSERT_NOW(a_hit_found, state_q == ST_FINISH, fin_q.found == (|hit_vec), "hit mismatch")

endmodule

`default_nettype wire

@@ sv/arpcr_cell.sv @@
// One cache entry of the ARP cache chain, with its stage of the search token.
// Depends on arpcr_pkg.
`default_nettype none

module arpcr_cell #(
	parameter int INDEX = 0,
	parameter int FW    = 5
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire [FW-1:0]             fill,
	input  wire arpcr_pkg::token_t   tin,
	output arpcr_pkg::token_t        tout,
	input  wire arpcr_pkg::cmd_t     cmd,
	output logic                     hit
);
	import arpcr_pkg::*;

	logic [31:0] ip_q;
	logic [47:0] mac_q;
	logic        cmpl_q;
	logic        hit_q;
	token_t      tok_q;
	logic        used;
	logic        match;
	logic        is_tail;

	assign used    = FW'(INDEX) < fill;
	assign is_tail = FW'(INDEX) == fill;
	assign match   = tin.valid && !tin.found && used && (ip_q == tin.key);

	// Only the first matching cell takes the token's hit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
			hit_q <= 1'b0;
		end else begin
			tok_q.valid <= tin.valid;
			tok_q.key   <= tin.key;
			tok_q.found <= tin.found || match;
			tok_q.mac   <= match ? mac_q : tin.mac;
			tok_q.cmpl  <= match ? cmpl_q : tin.cmpl;
			if (tin.valid) begin
				hit_q <= match;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmpl_q <= 1'b0;
		end else if (cmd.upd && hit_q) begin
			cmpl_q <= 1'b1;
		end else if (cmd.app && is_tail) begin
			cmpl_q <= cmd.cmpl;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd && hit_q) begin
			mac_q <= cmd.mac;
		end else if (cmd.app && is_tail) begin
			ip_q  <= cmd.ip;
			mac_q <= cmd.mac;
		end
	end

	assign tout = tok_q;
	assign hit  = hit_q;

endmodule

`default_nettype wire
